// ===== src/fls_pkg.sv =====
// ----------------------------------------------------------------------------
// fls_pkg
// Shared field widths, status codes and the result word type of the
// free-list index allocator.
// ----------------------------------------------------------------------------
package fls_pkg;

    localparam int IDX_W  = 10;
    localparam int CNT_W  = 7;
    localparam int FC_W   = 11;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              from_ram;
        logic [STAT_W-1:0] status;
        logic [FC_W-1:0]   free_count;
    } res_t;

endpackage

// ===== src/fls_stack_ram.sv =====
// ----------------------------------------------------------------------------
// fls_stack_ram
// Single write port, single read port storage for the free-index stack.
// Read data is registered.
// ----------------------------------------------------------------------------
module fls_stack_ram
    import fls_pkg::*;
#(
    parameter int ENTRIES = 1024,
    parameter int AW      = 10
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [IDX_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [IDX_W-1:0] rdata
);

    logic [IDX_W-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/fls_ctrl.sv =====
// ----------------------------------------------------------------------------
// fls_ctrl
// Sequencer of the allocator: clearing pass, command decode, top pointer
// and the one shared add/subtract unit that forms the new top pointer and the read address.
// ----------------------------------------------------------------------------
module fls_ctrl
    import fls_pkg::*;
#(
    parameter int ENTRIES   = 1024,
    parameter int MAX_BURST = 64,
    parameter int AW        = 10,
    parameter int PW        = 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             command,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] freed_index,
    output logic             busy,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output logic [IDX_W-1:0] mem_wdata,
    output logic             mem_re,
    output logic [AW-1:0]    mem_raddr,
    output res_t             res
);

    localparam int KW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
    localparam int CW = PW + CNT_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] top_reg, top_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] last_k_reg, last_k_next;
    logic [AW-1:0] clr_reg, clr_next;
    res_t          res_reg, res_next;

    // Shared add/subtract unit.
    logic [PW-1:0] op_b;
    logic          op_sub;
    logic [PW-1:0] alu_sum;

    logic [PW+CNT_W-1:0] count_wide;
    logic [PW+KW-1:0]    k_wide;
    logic [CW-1:0]       count_cmp;
    logic [CW-1:0]       top_cmp;
    logic [PW+FC_W-1:0]  top_fc_wide;
    logic [PW+FC_W-1:0]  sum_fc_wide;
    logic [AW+IDX_W-1:0] clr_wide;
    logic                top_full;

    assign count_wide  = {{PW{1'b0}}, count};
    assign k_wide      = {{PW{1'b0}}, k_reg};
    assign count_cmp   = {{PW{1'b0}}, count};
    assign top_cmp     = {{CNT_W{1'b0}}, top_reg};
    assign top_fc_wide = {{FC_W{1'b0}}, top_reg};
    assign sum_fc_wide = {{FC_W{1'b0}}, alu_sum};
    assign clr_wide    = {{IDX_W{1'b0}}, clr_reg};
    assign top_full    = (top_reg == PW'(ENTRIES));

    always_comb
    begin
        op_b   = k_wide[PW-1:0];
        op_sub = 1'b0;
        if (state_reg == S_IDLE)
        begin
            if (command == CMD_FREE)
            begin
                op_b = PW'(1);
            end
            else
            begin
                op_b   = count_wide[PW-1:0];
                op_sub = 1'b1;
            end
        end
    end

    assign alu_sum = op_sub ? (top_reg - op_b) : (top_reg + op_b);

    always_comb
    begin
        state_next  = state_reg;
        top_next    = top_reg;
        k_next      = k_reg;
        last_k_next = last_k_reg;
        clr_next    = clr_reg;
        mem_we      = 1'b0;
        mem_waddr   = top_reg[AW-1:0];
        mem_wdata   = freed_index;
        mem_re      = 1'b0;
        mem_raddr   = alu_sum[AW-1:0];
        res_next            = res_reg;
        res_next.valid      = 1'b0;
        res_next.last       = 1'b1;
        res_next.from_ram   = 1'b0;
        res_next.status     = STAT_OK;
        res_next.free_count = top_fc_wide[FC_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                // Entry i is loaded with i, one entry per cycle.
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = clr_wide[IDX_W-1:0];
                if (clr_reg == AW'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_FREE)
                    begin
                        res_next.valid = 1'b1;
                        if (top_full)
                        begin
                            res_next.status = STAT_OVERFLOW;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            top_next            = alu_sum;
                            res_next.free_count = sum_fc_wide[FC_W-1:0];
                        end
                    end
                    else if (count == '0)
                    begin
                        res_next.valid = 1'b1;
                    end
                    else if ((count > CNT_W'(MAX_BURST)) || (count_cmp > top_cmp))
                    begin
                        res_next.valid  = 1'b1;
                        res_next.status = STAT_NO_FREE;
                    end
                    else
                    begin
                        top_next    = alu_sum;
                        k_next      = '0;
                        last_k_next = KW'(count - CNT_W'(1));
                        state_next  = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                // One stack read per cycle at top + k; the word shows up on
                // the result ports with the registered read data.
                mem_re            = 1'b1;
                res_next.valid    = 1'b1;
                res_next.from_ram = 1'b1;
                res_next.last     = (k_reg == last_k_reg);
                if (k_reg == last_k_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            top_reg    <= PW'(ENTRIES);
            k_reg      <= '0;
            last_k_reg <= '0;
            clr_reg    <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            top_reg    <= top_next;
            k_reg      <= k_next;
            last_k_reg <= last_k_next;
            clr_reg    <= clr_next;
            res_reg    <= res_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign res  = res_reg;

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= PW'(ENTRIES))
        else $error("top pointer above stack depth");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.valid && res_reg.status != STAT_OK) |-> res_reg.last)
        else $error("error word not marked last");

    a_ram_word_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.valid && res_reg.from_ram) |-> $past(state_reg == S_RUN))
        else $error("stack word issued outside a burst");

    a_free_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE && command == CMD_FREE)
        |=> (res_reg.valid && res_reg.last && state_reg == S_IDLE))
        else $error("free did not give one word");

    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && k_reg == last_k_reg) |=> (state_reg == S_IDLE))
        else $error("burst ran past its count");

endmodule

// ===== src/free_list_index_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_index_allocator
// Stack of free slot indices with a top pointer: allocate pops a burst of
// indices in ascending stack order, free pushes one index.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------
//   command  | in        | start high, busy low      | command, count,
//            |           |                           | freed_index
//   result   | out       | result_valid, one cycle   | slot_index, last,
//            |           |                           | status, free_count
//
// After reset the stack is loaded with 0..ENTRIES-1, one entry per cycle,
// while busy stays high.
// A free, a zero count or a rejected allocate gives its one word in the
// cycle after the command is taken; busy does not rise.
// An allocate of count entries holds busy high while it makes one stack read
// per cycle on the single read port; each word follows its read in the next cycle.
// The receiver cannot stall; each word is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module free_list_index_allocator
    import fls_pkg::*;
#(
    parameter int ENTRIES   = 1024,
    parameter int MAX_BURST = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              command,
    input  logic [CNT_W-1:0]  count,
    input  logic [IDX_W-1:0]  freed_index,
    output logic              result_valid,
    output logic [IDX_W-1:0]  slot_index,
    output logic              last,
    output logic [STAT_W-1:0] status,
    output logic [FC_W-1:0]   free_count
);

    localparam int AW = $clog2(ENTRIES);
    localparam int PW = $clog2(ENTRIES + 1);

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [IDX_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [IDX_W-1:0] mem_rdata;
    res_t             res;

    fls_ctrl #(
        .ENTRIES   (ENTRIES),
        .MAX_BURST (MAX_BURST),
        .AW        (AW),
        .PW        (PW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .count       (count),
        .freed_index (freed_index),
        .busy        (busy),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .res         (res)
    );

    fls_stack_ram #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Only burst words carry a stack entry; every other word reads zero.
    assign slot_index   = res.from_ram ? mem_rdata : '0;
    assign result_valid = res.valid;
    assign last         = res.last;
    assign status       = res.status;
    assign free_count   = res.free_count;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the free-list index allocator. A scoreboard keeps
// its own copy of the free stack and top pointer, predicts every result word
// of each accepted command, and compares the words on the result port in
// order. Stimulus is a directed pass over the corner cases followed by random
// bulk frees and allocates under three sender idling profiles.
// ----------------------------------------------------------------------------
module testbench;
    import fls_pkg::*;

    localparam int ENTRIES    = 1024;
    localparam int MAX_BURST  = 64;
    localparam int QUIET_MAX  = 4096;
    localparam int RAND_ITEMS = 120;

    typedef struct {
        logic [IDX_W-1:0]  slot;
        logic              last;
        logic [STAT_W-1:0] status;
        logic [FC_W-1:0]   fc;
    } slot_word_t;

    class slot_ledger;
        logic [IDX_W-1:0] stack [ENTRIES];
        int unsigned      level;
        slot_word_t       awaited_words [$];
        int               errors;
        int               alloc_words;
        int               frees_taken;
        int               rejects;

        function new();
            for (int i = 0; i < ENTRIES; i++)
                stack[i] = IDX_W'(i);
            level = ENTRIES;
            errors = 0;
            alloc_words = 0;
            frees_taken = 0;
            rejects = 0;
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction

        function void take_command(logic cmd, logic [CNT_W-1:0] cnt,
                                   logic [IDX_W-1:0] idx);
            slot_word_t w;
            w.slot   = '0;
            w.last   = 1'b1;
            w.status = STAT_OK;
            if (cmd == CMD_FREE)
            begin
                if (level >= ENTRIES)
                begin
                    w.status = STAT_OVERFLOW;
                    rejects++;
                end
                else
                begin
                    stack[level] = idx;
                    level++;
                    frees_taken++;
                end
                w.fc = FC_W'(level);
                awaited_words.push_back(w);
            end
            else if (cnt == 0)
            begin
                w.fc = FC_W'(level);
                awaited_words.push_back(w);
            end
            else if (cnt > MAX_BURST || cnt > level)
            begin
                w.status = STAT_NO_FREE;
                w.fc = FC_W'(level);
                awaited_words.push_back(w);
                rejects++;
            end
            else
            begin
                level -= cnt;
                w.fc = FC_W'(level);
                for (int k = 0; k < cnt; k++)
                begin
                    w.slot = stack[level + k];
                    w.last = (k + 1 == cnt);
                    awaited_words.push_back(w);
                end
                alloc_words += cnt;
            end
        endfunction

        function void check_word(logic [IDX_W-1:0] slot, logic lst,
                                 logic [STAT_W-1:0] stat, logic [FC_W-1:0] fc);
            slot_word_t w;
            if (awaited_words.size() == 0)
            begin
                $error("unexpected result word: slot_index %0d status %0d", slot, stat);
                errors++;
                return;
            end
            w = awaited_words.pop_front();
            if (slot !== w.slot)
            begin
                $error("slot_index: expected %0d, actual %0d", w.slot, slot);
                errors++;
            end
            if (lst !== w.last)
            begin
                $error("last: expected %0d, actual %0d", w.last, lst);
                errors++;
            end
            if (stat !== w.status)
            begin
                $error("status: expected %0d, actual %0d", w.status, stat);
                errors++;
            end
            if (fc !== w.fc)
            begin
                $error("free_count: expected %0d, actual %0d", w.fc, fc);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              command = CMD_ALLOC;
    logic [CNT_W-1:0]  count = '0;
    logic [IDX_W-1:0]  freed_index = '0;
    logic              result_valid;
    logic [IDX_W-1:0]  slot_index;
    logic              last;
    logic [STAT_W-1:0] status;
    logic [FC_W-1:0]   free_count;

    slot_ledger sb;
    int         idle_pct = 0;
    int         sent = 0;
    int         quiet_cycles = 0;

    free_list_index_allocator #(
        .ENTRIES   (ENTRIES),
        .MAX_BURST (MAX_BURST)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .count        (count),
        .freed_index  (freed_index),
        .result_valid (result_valid),
        .slot_index   (slot_index),
        .last         (last),
        .status       (status),
        .free_count   (free_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Start stays high from one accepted word to the next unless an idle
    // cycle is drawn, so it is never lowered and raised in the same step.
    task automatic send_command(input logic cmd, input logic [CNT_W-1:0] cnt,
                                input logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        count       <= cnt;
        freed_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.take_command(cmd, cnt, idx);
        sent++;
    endtask

    task automatic send_alloc(input int cnt);
        send_command(CMD_ALLOC, CNT_W'(cnt), IDX_W'($urandom));
    endtask

    task automatic send_free(input int idx);
        send_command(CMD_FREE, CNT_W'($urandom), IDX_W'(idx));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_word(slot_index, last, status, free_count);
        if (rst_n && (result_valid || (start && !busy)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_MAX);
        $display("Watchdog: no activity for %0d cycles", QUIET_MAX);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int pick;
        int cap;
        int target;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner cases: overflow on a full stack, zero and oversized counts,
        // a full drain, underflow on an empty or nearly empty stack.
        idle_pct = 15;
        send_free(10'h155);
        send_alloc(0);
        send_alloc(127);
        send_alloc(MAX_BURST + 1);
        send_alloc(1);
        send_free(1023);
        repeat (ENTRIES / MAX_BURST) send_alloc(MAX_BURST);
        send_alloc(1);
        send_free(0);
        send_alloc(2);
        send_alloc(1);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 15 : (phase == 1) ? 60 : 0;
            target = sent + RAND_ITEMS / 3;
            while (sent < target)
            begin
                pick = $urandom_range(0, 99);
                cap = (sb.level < MAX_BURST) ? sb.level : MAX_BURST;
                if (pick < 40 || (pick < 85 && cap == 0))
                    repeat ($urandom_range(1, 16)) send_free($urandom);
                else if (pick < 80)
                    send_alloc($urandom_range(1, (cap < 8) ? cap : 8));
                else if (pick < 85)
                    send_alloc($urandom_range(1, cap));
                else if (pick < 90)
                    send_alloc(0);
                else if (pick < 95)
                    send_alloc($urandom_range(MAX_BURST + 1, 127));
                else
                    send_alloc($urandom_range(1, MAX_BURST));
            end
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d commands: %0d indices allocated, %0d frees pushed, %0d rejected.",
                 sent, sb.alloc_words, sb.frees_taken, sb.rejects);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== free_list_index_allocator.f =====
src/fls_pkg.sv
src/fls_stack_ram.sv
src/fls_ctrl.sv
src/free_list_index_allocator.sv
bench/testbench.sv
